FILE: sv/cnf_pkg.sv
// ----------------------------------------------------------------------------
// cnf_pkg
// Shared types, constants and the stripe sine helper for the cellular noise
// F2 minus F1 block.
// ----------------------------------------------------------------------------
package cnf_pkg;

  // Default parameter values
  localparam int SiteCountMaxDef   = 256;
  localparam int TexSizeMaxDef     = 1024;
  localparam int SineTableDepthDef = 1024;

  // Fixed field widths
  localparam int COORD_W  = 16;
  localparam int STEP_W   = 15;
  localparam int CNT_W    = 9;
  localparam int DIST_W   = 34;
  localparam int ROOT_W   = 17;
  localparam int COL_W    = 10;
  localparam int EDGE_W   = 18;
  localparam int MAX_W    = 17;
  localparam int STRIPE_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;
  localparam int COL_COUNT  = 2 ** COL_W;

  // World position and distance widths
  localparam int WORLD_W = 27;
  localparam int DIFF_W  = 28;
  localparam int ABS_W   = 27;
  localparam int SQ_W    = 54;
  localparam int SUM_W   = 55;

  // Q30 angle constants
  localparam longint unsigned Q30_TWO_PI  = 64'd6746518852;
  localparam longint unsigned Q30_PI      = 64'd3373259426;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint unsigned SERIES_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  localparam logic signed [EDGE_W:0] EDGE_HI = 19'sd131071;
  localparam logic signed [EDGE_W:0] EDGE_LO = -19'sd131072;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_STEP_X   = 3'd2,
    CFG_STEP_Y   = 3'd3,
    CFG_SITE_CNT = 3'd4,
    CFG_DIST_CAP = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WORLD,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]                kind;
    logic [7:0]                site_slot;
    logic signed [COORD_W-1:0] site_x;
    logic signed [COORD_W-1:0] site_y;
    logic [COL_W-1:0]          pixel_col;
    logic [COL_W-1:0]          pixel_row;
  } item_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] edge_value;
    logic [MAX_W-1:0]         running_max;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_we;
    logic clr_max;
    logic latch_px;
    logic world;
    logic issue;
    logic root_go;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_ok;
    logic pix_ok;
    logic issue_done;
    logic pipe_empty;
    logic root_done;
  } dp_sts_t;

  // Stripe value from a Q30 angle in [0, 2pi): 0.01 * sin in Q13, rounded
  function automatic logic signed [STRIPE_W-1:0] cnf_stripe_of_angle(
      input longint unsigned angle);
    longint unsigned a;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned nsum;
    longint unsigned mag;
    logic            neg;
    a    = angle;
    neg  = 1'b0;
    if (a > Q30_PI) begin
      neg = 1'b1;
      a   = Q30_TWO_PI - a;
    end
    if (a > Q30_HALF_PI) begin
      a = Q30_PI - a;
    end
    x2   = (a * a) >> 30;
    term = a;
    pos  = a;
    nsum = 0;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[k];
      if ((k % 2) == 1) nsum = nsum + term;
      else pos = pos + term;
    end
    mag = (pos > nsum) ? pos - nsum : 64'd0;
    mag = (mag * 64'd2048 + 64'd13421772800) / 64'd26843545600;
    return neg ? -STRIPE_W'(mag) : STRIPE_W'(mag);
  endfunction

endpackage

FILE: sv/cnf_ram.sv
// ----------------------------------------------------------------------------
// cnf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cnf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/cnf_isqrt.sv
// ----------------------------------------------------------------------------
// cnf_isqrt
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cnf_isqrt import cnf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIST_W-1:0] val_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [DIST_W-1:0]   val_q;
  logic [ROOT_W+1:0]   rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [4:0]          cnt_q;
  logic                run_q;
  logic                done_q;
  logic [ROOT_W+3:0]   rem_sh;
  logic [ROOT_W+3:0]   trial;

  // Bring down the next digit pair and try the next root bit
  assign rem_sh = {rem_q, val_q[DIST_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'(ROOT_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      val_q <= {val_q[DIST_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= (ROOT_W+2)'(rem_sh - trial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= (ROOT_W+2)'(rem_sh);
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: sv/cnf_ctrl.sv
// ----------------------------------------------------------------------------
// cnf_ctrl
// Sequencer: decodes beats, walks the site scan, square roots and result.
// ----------------------------------------------------------------------------
module cnf_ctrl import cnf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] kind_i,
  input  dp_sts_t    sts_i,
  output ctl_cmd_t   cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (kind_i)
            KIND_LOAD:  cmd_o.load_we = sts_i.slot_ok;
            KIND_CLEAR: cmd_o.clr_max = 1'b1;
            KIND_PIXEL: begin
              if (sts_i.pix_ok) begin
                cmd_o.latch_px = 1'b1;
                state_d        = ST_WORLD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WORLD: begin
        cmd_o.world = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.issue_done) state_d = ST_DRAIN;
        else cmd_o.issue = 1'b1;
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) begin
          cmd_o.root_go = 1'b1;
          state_d       = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sts_i.root_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: sv/cnf_dp.sv
// ----------------------------------------------------------------------------
// cnf_dp
// Datapath: config registers, site RAM, distance pipeline, minima, roots,
// stripe table and result register.
// ----------------------------------------------------------------------------
module cnf_dp import cnf_pkg::*; #(
  parameter int SITE_COUNT_MAX   = SiteCountMaxDef,
  parameter int TEX_SIZE_MAX     = TexSizeMaxDef,
  parameter int SINE_TABLE_DEPTH = SineTableDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  item_t                 item_i,
  input  ctl_cmd_t              cmd_i,
  output dp_sts_t               sts_o,
  output result_t               result_o,
  output logic                  res_valid_o
);

  localparam int AW = $clog2(SITE_COUNT_MAX);
  localparam int CW = $clog2(SITE_COUNT_MAX + 1);

  // Configuration registers
  logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
  logic [STEP_W-1:0]         step_x_q, step_y_q;
  logic [CNT_W-1:0]          site_count_q;
  logic [DIST_W-1:0]         dist_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= -16'sd8192;
      origin_y_q   <= -16'sd8192;
      step_x_q     <= 15'd32;
      step_y_q     <= 15'd32;
      site_count_q <= '0;
      dist_cap_q   <= 34'd1073741824;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X: origin_x_q   <= cfg_data_i[COORD_W-1:0];
        CFG_ORIGIN_Y: origin_y_q   <= cfg_data_i[COORD_W-1:0];
        CFG_STEP_X:   step_x_q     <= cfg_data_i[STEP_W-1:0];
        CFG_STEP_Y:   step_y_q     <= cfg_data_i[STEP_W-1:0];
        CFG_SITE_CNT: site_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_DIST_CAP: dist_cap_q   <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Beat range checks
  assign sts_o.slot_ok = (32'(item_i.site_slot) < SITE_COUNT_MAX);
  assign sts_o.pix_ok  = (32'(item_i.pixel_col) < TEX_SIZE_MAX) &&
                         (32'(item_i.pixel_row) < TEX_SIZE_MAX);

  // Pixel latch and world position
  logic [COL_W-1:0]          col_q, row_q;
  logic signed [WORLD_W-1:0] wx_q, wy_q;
  logic [CW-1:0]             idx_q, lim_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_px) begin
      col_q <= item_i.pixel_col;
      row_q <= item_i.pixel_row;
    end
    if (cmd_i.world) begin
      wx_q <= WORLD_W'(origin_x_q) +
              $signed({2'b00, (WORLD_W-2)'(col_q) * (WORLD_W-2)'(step_x_q)});
      wy_q <= WORLD_W'(origin_y_q) +
              $signed({2'b00, (WORLD_W-2)'(row_q) * (WORLD_W-2)'(step_y_q)});
      lim_q <= (32'(site_count_q) > SITE_COUNT_MAX) ? CW'(SITE_COUNT_MAX)
                                                   : CW'(site_count_q);
    end
  end

  // Advance the scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (cmd_i.world) idx_q <= '0;
    else if (cmd_i.issue) idx_q <= idx_q + CW'(1);
  end

  assign sts_o.issue_done = (idx_q >= lim_q);

  // Site store
  logic [2*COORD_W-1:0] site_rd;

  cnf_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (SITE_COUNT_MAX)
  ) u_site_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_we),
    .waddr_i (AW'(item_i.site_slot)),
    .wdata_i ({item_i.site_y, item_i.site_x}),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (site_rd)
  );

  // Distance pipeline: read, absolute deltas, squares, minima
  logic                     rd_v_q, ab_v_q, sq_v_q;
  logic [ABS_W-1:0]         ax_q, ay_q;
  logic [SQ_W-1:0]          sx_q, sy_q;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [SUM_W-1:0]         dsum;
  logic [DIST_W-1:0]        m0_q, m1_q;

  assign dx   = DIFF_W'(wx_q) - DIFF_W'($signed(site_rd[COORD_W-1:0]));
  assign dy   = DIFF_W'(wy_q) - DIFF_W'($signed(site_rd[2*COORD_W-1:COORD_W]));
  assign dsum = SUM_W'(sx_q) + SUM_W'(sy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      ab_v_q <= 1'b0;
      sq_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.issue;
      ab_v_q <= rd_v_q;
      sq_v_q <= ab_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= dx[DIFF_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    ay_q <= dy[DIFF_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
    sx_q <= ax_q * ax_q;
    sy_q <= ay_q * ay_q;
    if (cmd_i.world) begin
      m0_q <= dist_cap_q;
      m1_q <= dist_cap_q;
    end else if (sq_v_q) begin
      if (dsum < SUM_W'(m0_q)) begin
        m1_q <= m0_q;
        m0_q <= DIST_W'(dsum);
      end else if (dsum < SUM_W'(m1_q)) begin
        m1_q <= DIST_W'(dsum);
      end
    end
  end

  assign sts_o.pipe_empty = !rd_v_q && !ab_v_q && !sq_v_q;

  // Square roots of both minima
  logic [ROOT_W-1:0] r0, r1;
  logic              done0, done1;

  cnf_isqrt u_sqrt_f1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_go),
    .val_i   (m0_q),
    .done_o  (done0),
    .root_o  (r0)
  );

  cnf_isqrt u_sqrt_f2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_go),
    .val_i   (m1_q),
    .done_o  (done1),
    .root_o  (r1)
  );

  assign sts_o.root_done = done0 && done1;

  // Stripe table per column, registered read
  logic signed [STRIPE_W-1:0] stripe_rom [COL_COUNT];
  logic signed [STRIPE_W-1:0] stripe_q;

  for (genvar g = 0; g < COL_COUNT; g++) begin : g_stripe
    localparam longint unsigned PhaseIdx = (40 * g) % SINE_TABLE_DEPTH;
    localparam longint unsigned Angle    = PhaseIdx * Q30_TWO_PI / SINE_TABLE_DEPTH;
    assign stripe_rom[g] = cnf_stripe_of_angle(Angle);
  end

  always_ff @(posedge clk_i) begin
    stripe_q <= stripe_rom[col_q];
  end

  // Edge value, saturation and running maximum
  logic signed [EDGE_W:0]   edge_raw;
  logic signed [EDGE_W-1:0] edge_sat;
  logic [MAX_W-1:0]         max_q;
  result_t                  res_q;
  logic                     res_v_q;

  assign edge_raw = $signed({2'b00, r1}) - $signed({2'b00, r0}) +
                    (EDGE_W+1)'(stripe_q);

  always_comb begin
    if (edge_raw > EDGE_HI) edge_sat = EDGE_HI[EDGE_W-1:0];
    else if (edge_raw < EDGE_LO) edge_sat = EDGE_LO[EDGE_W-1:0];
    else edge_sat = edge_raw[EDGE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= '0;
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= cmd_i.emit;
      if (cmd_i.clr_max) begin
        max_q <= '0;
      end else if (cmd_i.emit && (edge_sat > $signed({1'b0, max_q}))) begin
        max_q <= edge_sat[MAX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.edge_value  <= edge_sat;
      res_q.running_max <= (edge_sat > $signed({1'b0, max_q})) ?
                           edge_sat[MAX_W-1:0] : max_q;
    end
  end

  assign result_o    = res_q;
  assign res_valid_o = res_v_q;

endmodule

FILE: sv/cellular_noise_f2_minus_f1.sv
// ----------------------------------------------------------------------------
// cellular_noise_f2_minus_f1
// Cellular noise F2 minus F1 with a column stripe and running maximum.
// ----------------------------------------------------------------------------
// A load or clear beat does not raise busy. A pixel beat keeps busy high
// until it emits its result: the first n sites, n being site_count capped at
// SITE_COUNT_MAX, are scanned one per cycle through the read port of the
// site RAM and a three-stage distance pipeline, then two 17-step square
// roots run side by side. The result appears on result_o for one cycle,
// marked by res_valid_o, and cannot be held off: the receiver must take it
// in that cycle. Out of range pixels, kind 3 beats, loads and clears give
// no result.
module cellular_noise_f2_minus_f1 import cnf_pkg::*; #(
  parameter int SITE_COUNT_MAX   = SiteCountMaxDef,
  parameter int TEX_SIZE_MAX     = TexSizeMaxDef,
  parameter int SINE_TABLE_DEPTH = SineTableDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item_i,
  output logic                  res_valid_o,
  output result_t               result_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequencer
  cnf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (item_i.kind),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Datapath
  cnf_dp #(
    .SITE_COUNT_MAX   (SITE_COUNT_MAX),
    .TEX_SIZE_MAX     (TEX_SIZE_MAX),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o),
    .res_valid_o (res_valid_o)
  );

`ifndef SYNTHESIS
  // One strobe per pixel
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  // Finishing a pixel always delivers its result
  a_fall_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("pixel finished without a result");

  // Running maximum covers a nonnegative edge value
  a_max_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !result_o.edge_value[EDGE_W-1]) |->
      (result_o.running_max >= result_o.edge_value[MAX_W-1:0]))
    else $error("running maximum below edge value");
`endif

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the cellular noise F2 minus F1 block. A directed table covers
// the field extremes, every kind of item, saturation, an empty scan and the
// register writes. Random phases with different register settings and sender
// idling follow. Every result beat is checked against a predictor of the
// nearest-site search, the square roots, the column stripe and the running
// maximum, or against the expected value that a table row gives.
// ----------------------------------------------------------------------------
module tb_top;
  import cnf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                   SITE_N      = 256;
  localparam logic [1:0]           KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;
  localparam longint unsigned      TWO_PI_Q30  = 64'd6746518852;
  localparam longint unsigned      PI_Q30      = 64'd3373259426;
  localparam longint unsigned      HALF_PI_Q30 = 64'd1686629713;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    item_t                 it;
    bit                    has_exp;
    result_t               exp;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  start = 1'b0;
  logic                  busy;
  item_t                 item_i = '0;
  logic                  res_valid_o;
  result_t               result_o;

  // Predictor state
  logic signed [15:0] org_x, org_y;
  logic [14:0]        stp_x, stp_y;
  logic [8:0]         scan_cnt;
  logic [33:0]        dist_cap;
  logic [31:0]        sites [SITE_N];
  logic [16:0]        max_q;

  result_t edge_q [$];
  row_t    dir_tab [$];
  int      fail_cnt = 0;
  int      idle_pct = 0;

  cellular_noise_f2_minus_f1 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .result_o   (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Floor square root, one bit per step from the top
  function automatic longint floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return longint'(r);
  endfunction

  // Column stripe: 0.01 * sin of the column phase, Q13, rounded half up
  function automatic longint col_stripe(logic [9:0] col);
    longint unsigned ph;
    longint unsigned ang;
    longint unsigned sq;
    longint unsigned trm;
    longint unsigned up;
    longint unsigned dn;
    longint unsigned mag;
    bit              neg;
    ph  = (64'd40 * col) % 64'd1024;
    ang = ph * TWO_PI_Q30 / 64'd1024;
    neg = 1'b0;
    if (ang > PI_Q30) begin
      neg = 1'b1;
      ang = TWO_PI_Q30 - ang;
    end
    if (ang > HALF_PI_Q30) ang = PI_Q30 - ang;
    sq  = (ang * ang) >> 30;
    trm = ang;
    up  = ang;
    dn  = 0;
    for (int k = 1; k <= 7; k++) begin
      trm = ((trm * sq) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) dn += trm;
      else up += trm;
    end
    mag = (up > dn) ? up - dn : 0;
    mag = (mag * 64'd2048 + 64'd25 * (64'd1 << 29)) / (64'd25 * (64'd1 << 30));
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // Register write as seen by the predictor
  function automatic void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_ORIGIN_X: org_x = d[15:0];
      CFG_ORIGIN_Y: org_y = d[15:0];
      CFG_STEP_X:   stp_x = d[14:0];
      CFG_STEP_Y:   stp_y = d[14:0];
      CFG_SITE_CNT: scan_cnt = d[8:0];
      CFG_DIST_CAP: dist_cap = d[33:0];
      default: ;
    endcase
  endfunction

  // Apply one beat to the predictor; returns 1 when a result is due
  function automatic bit edge_of_beat(item_t it, output result_t r);
    longint          wx, wy, dx, dy, e;
    longint unsigned d, m0, m1;
    int              n;
    r = '0;
    case (it.kind)
      KIND_LOAD: begin
        sites[it.site_slot] = {it.site_y, it.site_x};
        return 1'b0;
      end
      KIND_CLEAR: begin
        max_q = '0;
        return 1'b0;
      end
      KIND_PIXEL: begin
        n  = (scan_cnt > SITE_N) ? SITE_N : int'(scan_cnt);
        m0 = dist_cap;
        m1 = dist_cap;
        wx = longint'(org_x) + longint'(it.pixel_col) * longint'(stp_x);
        wy = longint'(org_y) + longint'(it.pixel_row) * longint'(stp_y);
        for (int i = 0; i < n; i++) begin
          dx = wx - longint'($signed(sites[i][15:0]));
          dy = wy - longint'($signed(sites[i][31:16]));
          d  = longint'(dx * dx + dy * dy);
          if (d < m0) begin
            m1 = m0;
            m0 = d;
          end else if (d < m1) begin
            m1 = d;
          end
        end
        e = floor_root(m1) - floor_root(m0) + col_stripe(it.pixel_col);
        if (e > 131071) e = 131071;
        if (e < -131072) e = -131072;
        if (e > longint'(max_q)) max_q = e[16:0];
        r.edge_value  = e[17:0];
        r.running_max = max_q;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_valid_o) begin
      if (edge_q.size() == 0) begin
        $display("%0t: result with none expected: edge %0d max %0d", $time,
                 result_o.edge_value, result_o.running_max);
        fail_cnt++;
      end else begin
        want = edge_q.pop_front();
        if (result_o.edge_value !== want.edge_value) begin
          $display("%0t: edge_value expected %0d got %0d", $time,
                   want.edge_value, result_o.edge_value);
          fail_cnt++;
        end
        if (result_o.running_max !== want.running_max) begin
          $display("%0t: running_max expected %0d got %0d", $time,
                   want.running_max, result_o.running_max);
          fail_cnt++;
        end
      end
    end
  end

  // Present one beat, hold it until taken, then predict
  task automatic push_beat(item_t it, bit has_exp, result_t exp);
    result_t r;
    int      gap;
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    if (edge_of_beat(it, r)) edge_q.push_back(has_exp ? exp : r);
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drop start and wait until the block has nothing left in flight
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    note_reg(idx, d);
  endtask

  function automatic item_t mk(logic [1:0] k, logic [7:0] s, logic [15:0] x,
                               logic [15:0] y, logic [9:0] c, logic [9:0] r);
    item_t it;
    it.kind      = k;
    it.site_slot = s;
    it.site_x    = x;
    it.site_y    = y;
    it.pixel_col = c;
    it.pixel_row = r;
    return it;
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    row_t w;
    w        = '{default: '0};
    w.is_cfg = 1'b1;
    w.idx    = idx;
    w.data   = d;
    dir_tab.push_back(w);
  endfunction

  function automatic void add_beat(item_t it, bit has_exp = 1'b0,
                                   logic [17:0] e = '0, logic [16:0] m = '0);
    row_t w;
    w                   = '{default: '0};
    w.it                = it;
    w.has_exp           = has_exp;
    w.exp.edge_value    = e;
    w.exp.running_max   = m;
    dir_tab.push_back(w);
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t rand_beat();
    logic [63:0] raw;
    item_t       it;
    int          pick;
    raw  = {$urandom, $urandom};
    it   = raw[61:0];
    pick = $urandom_range(99);
    if (pick < 60) begin
      it.kind = KIND_PIXEL;
    end else if (pick < 85) begin
      it.kind   = KIND_LOAD;
      it.site_x = rand_coord();
      it.site_y = rand_coord();
    end else if (pick < 93) begin
      it.kind = KIND_CLEAR;
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  // Hard stop
  initial begin
    #40ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    result_t nil;
    item_t   it;
    int      n_items;
    nil = '0;
    org_x = -16'sd8192;
    org_y = -16'sd8192;
    stp_x = 15'd32;
    stp_y = 15'd32;
    scan_cnt = '0;
    dist_cap = 34'd1073741824;
    max_q = '0;
    foreach (sites[i]) sites[i] = '0;

    // Directed table
    add_beat(mk(KIND_PIXEL, 0, 0, 0, 0, 0), 1'b1, 18'd0, 17'd0);
    add_beat(mk(KIND_LOAD, 0, 16'h8000, 16'h8000, 0, 0));
    add_beat(mk(KIND_LOAD, 1, 16'h7FFF, 16'h7FFF, 0, 0));
    add_beat(mk(KIND_LOAD, 2, 16'h0000, 16'h0000, 0, 0));
    add_beat(mk(KIND_LOAD, 255, 16'h0001, 16'hFFFF, 0, 0));
    add_beat(mk(KIND_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF));
    add_beat(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
    add_cfg(CFG_SITE_CNT, 34'd3);
    add_beat(mk(KIND_PIXEL, 0, 0, 0, 1023, 1023));
    add_beat(mk(KIND_PIXEL, 0, 0, 0, 0, 0));
    add_beat(mk(KIND_PIXEL, 0, 0, 0, 512, 300));
    add_cfg(CFG_ORIGIN_X, 34'h07FFF);
    add_cfg(CFG_ORIGIN_Y, 34'h08000);
    add_cfg(CFG_STEP_X, 34'h7FFF);
    add_cfg(CFG_STEP_Y, 34'd0);
    add_beat(mk(KIND_PIXEL, 0, 0, 0, 1023, 5));
    add_beat(mk(KIND_PIXEL, 0, 0, 0, 20, 1023));
    // Pixel sits on site 0, second minimum stays at the widest cap: saturate
    add_cfg(CFG_ORIGIN_X, 34'h08000);
    add_cfg(CFG_STEP_X, 34'd0);
    add_cfg(CFG_SITE_CNT, 34'd1);
    add_cfg(CFG_DIST_CAP, 34'h3FFFFFFFF);
    add_beat(mk(KIND_PIXEL, 0, 0, 0, 1, 9), 1'b1, 18'd131071, 17'd131071);
    add_cfg(CFG_UNUSED, 34'h3FFFFFFFF);
    add_beat(mk(KIND_PIXEL, 0, 0, 0, 20, 0));
    add_cfg(CFG_DIST_CAP, 34'd0);
    add_beat(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
    add_beat(mk(KIND_PIXEL, 0, 0, 0, 256, 0), 1'b1, 18'd0, 17'd0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        push_beat(dir_tab[i].it, dir_tab[i].has_exp, dir_tab[i].exp);
      end
    end

    // Fill the whole site store so that any scan length is safe
    for (int s = 0; s < SITE_N; s++) begin
      push_beat(mk(KIND_LOAD, 8'(s), rand_coord(), rand_coord(), 0, 0), 1'b0, nil);
    end

    // Random phases, each with its own register setting and idling
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_ORIGIN_X, 34'h3E000);
          write_reg(CFG_ORIGIN_Y, 34'h3E000);
          write_reg(CFG_STEP_X, 34'd32);
          write_reg(CFG_STEP_Y, 34'd32);
          write_reg(CFG_SITE_CNT, 34'd8);
          write_reg(CFG_DIST_CAP, 34'd1073741824);
        end
        1: begin
          write_reg(CFG_ORIGIN_X, 34'h08000);
          write_reg(CFG_ORIGIN_Y, 34'h08000);
          write_reg(CFG_STEP_X, 34'h7FFF);
          write_reg(CFG_STEP_Y, 34'h7FFF);
          write_reg(CFG_SITE_CNT, 34'd511);
          write_reg(CFG_DIST_CAP, 34'h3FFFFFFFF);
        end
        2: begin
          write_reg(CFG_ORIGIN_X, 34'h07FFF);
          write_reg(CFG_ORIGIN_Y, 34'h07FFF);
          write_reg(CFG_STEP_X, 34'd0);
          write_reg(CFG_STEP_Y, 34'd0);
          write_reg(CFG_SITE_CNT, 34'd256);
          write_reg(CFG_DIST_CAP, 34'd0);
        end
        default: begin
          write_reg(CFG_ORIGIN_X, 34'($urandom_range(65535)));
          write_reg(CFG_ORIGIN_Y, 34'($urandom_range(65535)));
          write_reg(CFG_STEP_X, 34'($urandom_range(32767)));
          write_reg(CFG_STEP_Y, 34'($urandom_range(32767)));
          write_reg(CFG_SITE_CNT, 34'($urandom_range(0, 12)));
          write_reg(CFG_DIST_CAP, {2'($urandom_range(3)), $urandom});
        end
      endcase
      case (ph % 4)
        1:       idle_pct = 69;
        3:       idle_pct = 26;
        default: idle_pct = 0;
      endcase
      n_items = 117;
      for (int i = 0; i < n_items; i++) begin
        // Hold off once until every pending result is back
        if (ph == 4 && i == n_items / 2) begin
          @(negedge clk_i);
          start <= 1'b0;
          while (edge_q.size() != 0) @(posedge clk_i);
        end
        it = rand_beat();
        push_beat(it, 1'b0, nil);
      end
    end

    // Let the last results arrive
    drain();
    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
